// File: src/fir_pkg.sv
// Shared widths and types for the FIR filter.
package fir_pkg;

    localparam int SMP_W     = 16;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = SMP_W + COEF_W;
    localparam int ACC_W     = 35;
    localparam int NUM_COEF  = 8;
    localparam int CFG_IDX_W = $clog2(NUM_COEF);

    typedef logic signed [SMP_W-1:0]  t_smp;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;

endpackage

// File: src/fir_cell.sv
// One multiply-accumulate cell of the FIR chain.
module fir_cell #(
    parameter int WIN_N = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  fir_pkg::t_coef  i_coef,
    input  logic            i_valid,
    input  fir_pkg::t_smp   i_win [WIN_N],
    input  fir_pkg::t_prod  i_prod,
    input  fir_pkg::t_acc   i_sum,
    output logic            o_valid,
    output fir_pkg::t_smp   o_win [WIN_N],
    output fir_pkg::t_prod  o_prod,
    output fir_pkg::t_acc   o_sum
);
    import fir_pkg::*;

    logic  r_valid;
    t_smp  r_win [WIN_N];
    t_prod r_prod;
    t_acc  r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // window slides down one place per cell, so entry 1 is always this cell's tap
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int j = 0; j < WIN_N - 1; j++) begin
                r_win[j] <= i_win[j+1];
            end
            r_win[WIN_N-1] <= '0;
            r_prod <= t_prod'(i_coef) * t_prod'(i_win[1]);
            r_sum  <= i_sum + t_acc'(i_prod);
        end
    end

    assign o_valid = r_valid;
    assign o_win   = r_win;
    assign o_prod  = r_prod;
    assign o_sum   = r_sum;

endmodule

// File: src/fir_filter.sv
// Direct-form FIR filter built as a chain of multiply-accumulate cells.
//
//   channel   signals                                   dir
//   input     i_valid / o_stall, i_sample_in,
//             i_start_of_pulse                          in
//   output    o_valid / i_stall, o_filtered_out         out
//   config    i_cfg_we, i_cfg_index, i_cfg_data         in
//
// One beat in per cycle, one beat out per cycle while the output is not stalled; the
// path is registered in the entry stage, TAPS-1 cells and the output register.
// Reset clears the coefficients, the delay line and all valid flags.
// A stalled output freezes the whole chain and raises o_stall in the same cycle.
module fir_filter #(
    parameter int TAPS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  fir_pkg::t_smp                 i_sample_in,
    input  logic                          i_start_of_pulse,
    output logic                          o_valid,
    input  logic                          i_stall,
    output fir_pkg::t_acc                 o_filtered_out,
    input  logic                          i_cfg_we,
    input  logic [fir_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  fir_pkg::t_coef                i_cfg_data
);
    import fir_pkg::*;

    localparam int DLY_N = (TAPS > 1) ? TAPS - 1 : 1;

    t_coef r_coef [NUM_COEF];
    t_smp  r_dly  [DLY_N];

    logic  adv;
    logic  acc_in;
    t_smp  win_in [TAPS];

    logic  s_valid [TAPS];
    t_smp  s_win   [TAPS][TAPS];
    t_prod s_prod  [TAPS];
    t_acc  s_sum   [TAPS];

    logic  r_out_valid;
    t_acc  r_out;

    assign adv     = !r_out_valid || !i_stall;
    assign o_stall = !adv;
    assign acc_in  = i_valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // sample window seen by this beat; start of pulse zeroes the history
    always_comb begin
        win_in[0] = i_sample_in;
        for (int j = 1; j < TAPS; j++) begin
            win_in[j] = i_start_of_pulse ? t_smp'(0) : r_dly[j-1];
        end
    end

    generate
        if (TAPS > 1) begin : g_dly
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    for (int j = 0; j < DLY_N; j++) begin
                        r_dly[j] <= '0;
                    end
                end else if (acc_in) begin
                    r_dly[0] <= i_sample_in;
                    for (int j = 1; j < DLY_N; j++) begin
                        r_dly[j] <= win_in[j];
                    end
                end
            end
        end else begin : g_no_dly
            always_ff @(posedge i_clk) begin
                r_dly[0] <= '0;
            end
        end
    endgenerate

    // entry stage: tap 0 product, empty partial sum
    logic  r_v0;
    t_smp  r_win0 [TAPS];
    t_prod r_prod0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_win0  <= win_in;
            r_prod0 <= t_prod'(r_coef[0]) * t_prod'(i_sample_in);
        end
    end

    assign s_valid[0] = r_v0;
    assign s_win[0]   = r_win0;
    assign s_prod[0]  = r_prod0;
    assign s_sum[0]   = '0;

    generate
        for (genvar k = 1; k < TAPS; k++) begin : g_cell
            fir_cell #(
                .WIN_N (TAPS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_coef  (r_coef[k]),
                .i_valid (s_valid[k-1]),
                .i_win   (s_win[k-1]),
                .i_prod  (s_prod[k-1]),
                .i_sum   (s_sum[k-1]),
                .o_valid (s_valid[k]),
                .o_win   (s_win[k]),
                .o_prod  (s_prod[k]),
                .o_sum   (s_sum[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= s_valid[TAPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= s_sum[TAPS-1] + t_acc'(s_prod[TAPS-1]);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_filtered_out = r_out;

endmodule
